FILE: rtl/osm_pkg.sv
// Package with the shared types and constants of the order-statistic multiset.
`timescale 1ns / 1ps
package osm_pkg;
  localparam int DEFAULT_CAPACITY = 256;
  localparam int KEY_W = 32;
  localparam int RANK_W = 9;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FEW    = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_REM_RD,
    S_REM_CMP,
    S_SHL_RD,
    S_SHL_WR,
    S_QRY_WAIT,
    S_DONE
  } state_t;
endpackage

FILE: rtl/osm_if.sv
// Handshake interfaces for the request and result channels of the multiset.
`timescale 1ns / 1ps
interface osm_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       action;
  logic signed [osm_pkg::KEY_W-1:0] key;
  logic [osm_pkg::RANK_W-1:0]       rank;
  modport source (output valid, action, key, rank, input ready);
  modport sink (input valid, action, key, rank, output ready);
endinterface

interface osm_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       status;
  logic signed [osm_pkg::KEY_W-1:0] value;
  logic [osm_pkg::RANK_W-1:0]       count;
  modport source (output valid, status, value, count, input ready);
  modport sink (input valid, status, value, count, output ready);
endinterface

FILE: rtl/order_statistic_multiset_unit.sv
// Top level of the order-statistic multiset: a sorted key memory with a sequencer.
//
// Requests arrive on in_ch, one transaction per insert, remove or query, and
// each request yields exactly one result transaction on out_ch.
// Keys are held in ascending order in a single-port-write memory with a
// registered read. An insert walks down from the top entry, shifting larger
// keys up by one, with a read state and a compare state per moved entry.
// A remove scans up from the bottom for a match, with a read and a compare
// state per entry, then shifts the upper keys down with a read and a write
// state per entry. A query reads one entry. So the time an item takes is
// set by its walk over the key memory.
// A new request is taken only when the sequencer is idle; a finished result
// sits in the output register while the next request is already running.
// When the receiver stalls, at most one further result waits internally and
// the sequencer holds until the output register frees.
// Reset empties the multiset at once by clearing the key count; the memory
// needs no clearing pass since only entries below the count are read.
`timescale 1ns / 1ps
module order_statistic_multiset_unit #(
  parameter int CAPACITY = osm_pkg::DEFAULT_CAPACITY
) (
  input logic clk,
  input logic rst,
  osm_in_if.sink    in_ch,
  osm_out_if.source out_ch
);
  import osm_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > RANK_W) ? CW : RANK_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [KEY_W-1:0] mem [CAPACITY];
  logic [AW-1:0]           raddr;
  logic [AW-1:0]           waddr;
  logic signed [KEY_W-1:0] wdata;
  logic                    we;
  logic signed [KEY_W-1:0] rdata;

  state_t                  state, state_next;
  logic [CW-1:0]           cnt, cnt_next;
  logic [CW-1:0]           pos, pos_next;
  logic signed [KEY_W-1:0] op_key, op_key_next;
  status_t                 rs_status, rs_status_next;
  logic signed [KEY_W-1:0] rs_value, rs_value_next;
  logic                    o_valid, o_valid_next;
  logic [1:0]              o_status, o_status_next;
  logic signed [KEY_W-1:0] o_value, o_value_next;
  logic [RANK_W-1:0]       o_count, o_count_next;

  logic [XW-1:0] rank_x;
  logic [XW-1:0] cnt_x;
  logic [CW-1:0] qidx;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      o_valid <= o_valid_next;
    end
    pos       <= pos_next;
    op_key    <= op_key_next;
    rs_status <= rs_status_next;
    rs_value  <= rs_value_next;
    o_status  <= o_status_next;
    o_value   <= o_value_next;
    o_count   <= o_count_next;
  end

  assign rank_x = XW'(in_ch.rank);
  assign cnt_x  = XW'(cnt);
  assign qidx   = cnt - CW'(in_ch.rank);

  assign in_ch.ready   = (state == S_IDLE);
  assign out_ch.valid  = o_valid;
  assign out_ch.status = o_status;
  assign out_ch.value  = o_value;
  assign out_ch.count  = o_count;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    pos_next       = pos;
    op_key_next    = op_key;
    rs_status_next = rs_status;
    rs_value_next  = rs_value;
    o_valid_next   = o_valid && !out_ch.ready;
    o_status_next  = o_status;
    o_value_next   = o_value;
    o_count_next   = o_count;
    raddr          = pos[AW-1:0];
    waddr          = pos[AW-1:0];
    wdata          = op_key;
    we             = 1'b0;

    case (state)
      S_IDLE: begin
        raddr = qidx[AW-1:0];
        if (in_ch.valid) begin
          op_key_next    = in_ch.key;
          rs_status_next = ST_OK;
          rs_value_next  = '0;
          state_next     = S_DONE;
          case (action_t'(in_ch.action))
            ACT_INSERT: begin
              if (cnt >= CAP_C) begin
                rs_status_next = ST_FULL;
              end else if (cnt == '0) begin
                we       = 1'b1;
                waddr    = '0;
                wdata    = in_ch.key;
                cnt_next = cnt + 1'b1;
              end else begin
                pos_next   = cnt;
                state_next = S_INS_RD;
              end
            end
            ACT_REMOVE: begin
              if (cnt == '0) begin
                rs_status_next = ST_ABSENT;
              end else begin
                pos_next   = '0;
                state_next = S_REM_RD;
              end
            end
            ACT_QUERY: begin
              if (rank_x == '0 || rank_x > cnt_x) begin
                rs_status_next = ST_FEW;
                rs_value_next  = '1;
              end else begin
                state_next = S_QRY_WAIT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        raddr      = pos[AW-1:0] - 1'b1;
        state_next = S_INS_CMP;
      end
      S_INS_CMP: begin
        we = 1'b1;
        if (rdata > op_key) begin
          wdata      = rdata;
          pos_next   = pos - 1'b1;
          state_next = (pos == CW'(1)) ? S_INS_PUT : S_INS_RD;
        end else begin
          cnt_next   = cnt + 1'b1;
          state_next = S_DONE;
        end
      end
      S_INS_PUT: begin
        we         = 1'b1;
        cnt_next   = cnt + 1'b1;
        state_next = S_DONE;
      end
      S_REM_RD: begin
        state_next = S_REM_CMP;
      end
      S_REM_CMP: begin
        if (rdata == op_key) begin
          if (pos + 1'b1 < cnt) begin
            state_next = S_SHL_RD;
          end else begin
            cnt_next   = cnt - 1'b1;
            state_next = S_DONE;
          end
        end else if (pos + 1'b1 >= cnt) begin
          rs_status_next = ST_ABSENT;
          state_next     = S_DONE;
        end else begin
          pos_next   = pos + 1'b1;
          state_next = S_REM_RD;
        end
      end
      S_SHL_RD: begin
        raddr      = pos[AW-1:0] + 1'b1;
        state_next = S_SHL_WR;
      end
      S_SHL_WR: begin
        we       = 1'b1;
        wdata    = rdata;
        pos_next = pos + 1'b1;
        if (pos + 2'd2 < cnt) begin
          state_next = S_SHL_RD;
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = S_DONE;
        end
      end
      S_QRY_WAIT: begin
        rs_value_next = rdata;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (!o_valid || out_ch.ready) begin
          o_valid_next  = 1'b1;
          o_status_next = rs_status;
          o_value_next  = rs_value;
          o_count_next  = RANK_W'(cnt);
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CAP_C)
    else $error("key count exceeds capacity");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state != S_IDLE))
    else $error("sequencer idle right after a request");
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rs_status == ST_FULL) |-> (cnt == CAP_C))
    else $error("full status with free space");
`endif
endmodule

FILE: tb/order_statistic_multiset_unit_test.sv
// Testbench for the order-statistic multiset, checked against a sorted-array predictor.
`timescale 1ns / 1ps
module order_statistic_multiset_unit_test;
  import osm_pkg::*;

  localparam int CAP = DEFAULT_CAPACITY;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [8:0]  count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  osm_in_if in_ch ();
  osm_out_if out_ch ();

  order_statistic_multiset_unit #(.CAPACITY(CAP)) u_dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  logic signed [31:0] held_keys[$];
  outcome_t pending_outcomes[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off = 0;

  function automatic outcome_t predict_outcome(action_t act, logic signed [31:0] key,
                                               logic [8:0] rank);
    outcome_t o;
    int pos;
    o.status = ST_OK;
    o.value = '0;
    case (act)
      ACT_INSERT: begin
        if (held_keys.size() >= CAP) begin
          o.status = ST_FULL;
        end else begin
          pos = held_keys.size();
          while (pos > 0 && held_keys[pos-1] > key) pos--;
          held_keys.insert(pos, key);
        end
      end
      ACT_REMOVE: begin
        pos = -1;
        foreach (held_keys[i]) if (pos < 0 && held_keys[i] == key) pos = i;
        if (pos < 0) o.status = ST_ABSENT;
        else held_keys.delete(pos);
      end
      ACT_QUERY: begin
        if (rank == 0 || rank > held_keys.size()) begin
          o.status = ST_FEW;
          o.value = '1;
        end else begin
          o.value = held_keys[held_keys.size() - rank];
        end
      end
      default: ;
    endcase
    o.count = 9'(held_keys.size());
    return o;
  endfunction

  task automatic send_request(action_t act, logic signed [31:0] key, logic [8:0] rank);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.key <= key;
    in_ch.rank <= rank;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_outcomes.push_back(predict_outcome(act, key, rank));
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      outcome_t got, want;
      got = '{out_ch.status, out_ch.value, out_ch.count};
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                     want.status, $signed(want.value), want.count,
                     got.status, $signed(got.value), got.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
    end
  end

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(3, 0))
      0: return $urandom;
      1: return $signed($urandom_range(16, 0)) - 8;
      2: return held_keys.size() > 0 ? held_keys[$urandom_range(held_keys.size() - 1, 0)]
                                     : $urandom;
      default: return $urandom_range(1, 0) ? 32'sh7fffffff : 32'sh80000000;
    endcase
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_outcomes.size() > 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(ACT_QUERY, 0, 9'd1);
    send_request(ACT_REMOVE, 5, 9'd0);
    send_request(ACT_INSERT, 32'sh7fffffff, 9'd0);
    send_request(ACT_INSERT, 32'sh80000000, 9'd0);
    send_request(ACT_INSERT, 0, 9'd0);
    send_request(ACT_INSERT, -1, 9'd0);
    send_request(ACT_INSERT, 0, 9'd0);
    send_request(ACT_QUERY, 0, 9'd1);
    send_request(ACT_QUERY, 0, 9'd5);
    send_request(ACT_QUERY, 0, 9'd0);
    send_request(ACT_QUERY, 0, 9'd6);
    send_request(ACT_QUERY, 32'shffffffff, 9'h1ff);
    send_request(ACT_NONE, 32'shffffffff, 9'h1ff);
    send_request(ACT_REMOVE, 0, 9'd0);
    send_request(ACT_REMOVE, 12345, 9'd0);
    send_request(ACT_REMOVE, 32'sh80000000, 9'd0);
    send_request(ACT_QUERY, 0, 9'd3);
    drain();
  endtask

  task automatic test_fill_and_overflow();
    repeat (CAP + 4) send_request(ACT_INSERT, pick_key(), 9'd0);
    send_request(ACT_QUERY, 0, 9'd256);
    send_request(ACT_QUERY, 0, 9'd257);
    send_request(ACT_QUERY, 0, 9'd1);
    drain();
    hold_off <= 300;
    repeat (20) send_request(ACT_QUERY, 0, 9'($urandom_range(CAP, 1)));
    drain();
    while (held_keys.size() > 0)
      send_request(ACT_REMOVE, held_keys[$urandom_range(held_keys.size() - 1, 0)], 9'd0);
    drain();
  endtask

  task automatic test_random(int n);
    int a;
    repeat (n) begin
      a = $urandom_range(99, 0);
      if (a < 40) send_request(ACT_INSERT, pick_key(), 9'd0);
      else if (a < 65) send_request(ACT_REMOVE, pick_key(), 9'd0);
      else if (a < 97) send_request(ACT_QUERY, $urandom,
                                    9'($urandom_range(3, 0) == 0 ? $urandom_range(511, 0)
                                       : $urandom_range(held_keys.size() + 1, 0)));
      else send_request(ACT_NONE, $urandom, 9'($urandom_range(511, 0)));
    end
    drain();
  endtask

  task automatic test_idle_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  test_random(250);
    send_idle_pct = 83; recv_stall_pct = 0;  test_random(250);
    send_idle_pct = 0;  recv_stall_pct = 83; test_random(250);
    send_idle_pct = 14; recv_stall_pct = 14; test_random(250);
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = ACT_NONE;
    in_ch.key = '0;
    in_ch.rank = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_fill_and_overflow();
    test_idle_phases();
    repeat (2000) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("order_statistic_multiset_unit_test: done, clean");
    end else begin
      $display("order_statistic_multiset_unit_test: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("order_statistic_multiset_unit_test: done, errors");
    $finish;
  end
endmodule

FILE: sim.f
rtl/osm_pkg.sv
rtl/osm_if.sv
rtl/order_statistic_multiset_unit.sv
tb/order_statistic_multiset_unit_test.sv
